### hw/rtl/erf_normal_cdf_approx_defines.svh
// ----------------------------------------------------------------------------
// erf_normal_cdf_approx_defines
// Assertion macros shared by the RTL files of the erf / normal CDF block.
// ----------------------------------------------------------------------------
`ifndef ERF_NORMAL_CDF_APPROX_DEFINES_SVH
`define ERF_NORMAL_CDF_APPROX_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ERF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ERF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/erf_pkg.sv
// ----------------------------------------------------------------------------
// erf_pkg
// Constants and stage map of the erf / normal CDF pipeline.
// ----------------------------------------------------------------------------
package erf_pkg;

    localparam int XW  = 17;  // scaled argument, 0..32768
    localparam int SW  = 36;  // polynomial sum, Q30
    localparam int QW  = 32;  // reciprocal, Q31
    localparam int HN  = 6;   // Horner steps
    localparam int DVN = 32;  // quotient bits, one per stage
    localparam int SQN = 4;   // squarings

    localparam int ST_SC  = 1;
    localparam int ST_D0  = ST_SC + HN + 1;
    localparam int ST_S0  = ST_D0 + DVN;
    localparam int ST_OUT = ST_S0 + SQN;
    localparam int NST    = ST_OUT + 1;

    localparam logic [63:0] A1 =
        (64'd705230784 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] A2 =
        (64'd422820123 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] A3 =
        (64'd92705272 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] A4 =
        (64'd1520143 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] A5 =
        (64'd2765672 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] A6 =
        (64'd430638 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;

    localparam logic [SW-1:0] COEF [0:HN] = '{
        SW'(64'd1073741824), A1[SW-1:0], A2[SW-1:0], A3[SW-1:0],
        A4[SW-1:0], A5[SW-1:0], A6[SW-1:0]
    };

    localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
    localparam logic [16:0] ONE_Q15       = 17'd32768;
    localparam logic [16:0] MAX_Q15       = 17'd32767;

endpackage

### hw/rtl/erf_normal_cdf_approx.sv
// ----------------------------------------------------------------------------
// erf_normal_cdf_approx
// Pipelined erf(x) / standard normal CDF, Abramowitz-Stegun 7.1.28.
// ----------------------------------------------------------------------------
// Usage:
//   Input item: i_arg_value, signed Q4.12, taken when i_in_valid is high
//   and o_in_stall is low. Result item: o_func_value, signed Q1.15, taken
//   when o_out_valid is high and i_out_stall is low.
//   i_cfg_wr_en / i_cfg_wr_data write the mode bit (0 erf, 1 normal CDF);
//   write it only while no item is in flight.
//   o_out_valid rises after the item has passed through 45 register
//   stages: input register, 1/sqrt2 scaling, 6 Horner stages, 32 divider
//   stages (one quotient bit each), 4 squaring stages and the output register.
//   Throughput is one item per cycle unless the output stalls; the long divider chain sets the depth.
//   When the output is stalled while valid, the whole pipeline holds and
//   o_in_stall rises; nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits and sets mode to erf.
// ----------------------------------------------------------------------------
`include "erf_normal_cdf_approx_defines.svh"

module erf_normal_cdf_approx
    import erf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_arg_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_func_value,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data
);

    logic           r_cfg_mode;
    logic [NST-1:0] r_vld;
    logic [NST-1:0] r_neg;
    logic [NST-1:0] r_mode;
    logic           w_en;

    logic [XW-1:0]  r_s0_mag;
    logic [XW-1:0]  w_s0_mag;
    logic [32:0]    w_sc_prod;
    logic [32:0]    w_sc_sum;

    logic [SW-1:0]  r_h_acc [0:HN];
    logic [XW-1:0]  r_h_x   [0:HN];

    logic [SW-1:0]  r_d_rem [0:DVN-1];
    logic [DVN-1:0] r_d_num [0:DVN-1];
    logic [QW-1:0]  r_d_q   [0:DVN-1];
    logic [SW-1:0]  r_d_s   [0:DVN-1];

    logic [QW-1:0]  r_sq    [0:SQN-1];

    logic [32:0]    w_o_sum;
    logic [16:0]    w_o_q;
    logic [16:0]    w_o_qc;
    logic [16:0]    w_o_e;
    logic [15:0]    w_o_ec;
    logic [16:0]    w_o_v;
    logic [16:0]    w_o_h;
    logic [15:0]    w_o_res;
    logic [15:0]    r_out_val;

    assign w_en         = !(r_vld[NST-1] && i_out_stall);
    assign o_in_stall   = !w_en;
    assign o_out_valid  = r_vld[NST-1];
    assign o_func_value = r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_mode <= i_cfg_wr_data;
            end
            if (w_en) begin
                r_vld <= {r_vld[NST-2:0], i_in_valid};
            end
        end
    end

    // stage 0: magnitude
    assign w_s0_mag = i_arg_value[15] ? (17'h10000 - {1'b0, i_arg_value})
                                      : {1'b0, i_arg_value};

    // stage 1: optional 1/sqrt2 scaling
    assign w_sc_prod = 33'(r_s0_mag) * 33'(INV_SQRT2_Q16);
    assign w_sc_sum  = w_sc_prod + 33'd32768;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg      <= {r_neg[NST-2:0], i_arg_value[15]};
            r_mode     <= {r_mode[NST-2:0], r_cfg_mode};
            r_s0_mag   <= w_s0_mag;
            r_h_acc[0] <= COEF[HN];
            r_h_x[0]   <= r_mode[0] ? w_sc_sum[32:16] : r_s0_mag;
        end
    end

    // Horner stages
    for (genvar h = 1; h <= HN; h++) begin : g_horner
        logic [SW+XW-1:0] w_prod;
        logic [SW+XW-1:0] w_sum;
        assign w_prod = (SW+XW)'(r_h_acc[h-1]) * (SW+XW)'(r_h_x[h-1]);
        assign w_sum  = w_prod + (SW+XW)'(2048);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_h_acc[h] <= w_sum[SW+11:12] + COEF[HN-h];
                r_h_x[h]   <= r_h_x[h-1];
            end
        end
    end

    // restoring divider: (2^61 + s/2) / s, one quotient bit per stage
    for (genvar j = 0; j < DVN; j++) begin : g_div
        logic [SW-1:0]  w_rem;
        logic [DVN-1:0] w_num;
        logic [QW-1:0]  w_q;
        logic [SW-1:0]  w_s;
        logic [SW:0]    w_trial;
        logic           w_ge;
        if (j == 0) begin : g_first
            assign w_s   = r_h_acc[HN];
            assign w_rem = SW'(36'h20000000) + SW'(r_h_acc[HN][SW-1:33]);
            assign w_num = r_h_acc[HN][DVN:1];
            assign w_q   = '0;
        end else begin : g_next
            assign w_s   = r_d_s[j-1];
            assign w_rem = r_d_rem[j-1];
            assign w_num = r_d_num[j-1];
            assign w_q   = r_d_q[j-1];
        end
        assign w_trial = {w_rem, w_num[DVN-1]};
        assign w_ge    = w_trial >= {1'b0, w_s};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d_rem[j] <= w_ge ? SW'(w_trial - {1'b0, w_s}) : w_trial[SW-1:0];
                r_d_num[j] <= {w_num[DVN-2:0], 1'b0};
                r_d_q[j]   <= {w_q[QW-2:0], w_ge};
                r_d_s[j]   <= w_s;
            end
        end
    end

    // four squarings: 1/S^16
    for (genvar i = 0; i < SQN; i++) begin : g_sq
        logic [QW-1:0]   w_src;
        logic [2*QW-1:0] w_p;
        if (i == 0) begin : g_first
            assign w_src = r_d_q[DVN-1];
        end else begin : g_next
            assign w_src = r_sq[i-1];
        end
        assign w_p = (2*QW)'(w_src) * (2*QW)'(w_src) + (2*QW)'(64'h40000000);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[i] <= w_p[62:31];
            end
        end
    end

    // output stage: sign repair and mode select
    assign w_o_sum = {1'b0, r_sq[SQN-1]} + 33'd32768;
    assign w_o_q   = w_o_sum[32:16];
    assign w_o_qc  = (w_o_q > ONE_Q15) ? ONE_Q15 : w_o_q;
    assign w_o_e   = ONE_Q15 - w_o_qc;
    assign w_o_ec  = (w_o_e > MAX_Q15) ? MAX_Q15[15:0] : w_o_e[15:0];
    assign w_o_v   = r_neg[ST_OUT-1] ? (ONE_Q15 - w_o_e) : (ONE_Q15 + w_o_e);
    assign w_o_h   = (w_o_v + 17'd1) >> 1;

    always_comb begin
        if (r_mode[ST_OUT-1]) begin
            w_o_res = (w_o_h > MAX_Q15) ? MAX_Q15[15:0] : w_o_h[15:0];
        end else begin
            w_o_res = r_neg[ST_OUT-1] ? (16'd0 - w_o_ec) : w_o_ec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_val <= w_o_res;
        end
    end

    `ERF_ASSERT_IMPL(a_erf_pos, r_vld[ST_OUT] && !r_mode[ST_OUT] && !r_neg[ST_OUT], !o_func_value[15], "positive erf argument gave negative result")
    `ERF_ASSERT_IMPL(a_cdf_pos, r_vld[ST_OUT] && r_mode[ST_OUT], !o_func_value[15], "normal CDF result negative")
    `ERF_ASSERT_IMPL(a_div_rng, r_vld[ST_S0-1], r_d_q[DVN-1] <= 32'h80000000, "reciprocal above one")
    `ERF_ASSERT_NEXT(a_hold, !w_en, $stable(r_vld) && $stable(r_out_val), "pipeline moved while stalled")

endmodule
